@@ rtl/core/pds_pkg.sv @@
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and widths for the pair difference search block.
// ----------------------------------------------------------------------------
package pds_pkg;

  // Width of one stored element.
  localparam int unsigned VALUE_W = 32;

  // One element of the set, two's complement.
  typedef logic signed [VALUE_W-1:0] value_t;

endpackage : pds_pkg

@@ rtl/core/pds_in_if.sv @@
// ----------------------------------------------------------------------------
// pds_in_if
// Input channel: one element word per handshake, with a last marker.
// ----------------------------------------------------------------------------
interface pds_in_if;
  import pds_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;
  logic   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);

endinterface : pds_in_if

@@ rtl/core/pds_out_if.sv @@
// ----------------------------------------------------------------------------
// pds_out_if
// Result channel: one result word per closed set.
// ----------------------------------------------------------------------------
interface pds_out_if;

  logic valid;
  logic ready;
  logic found;
  logic overflowed;

  modport source (output valid, output found, output overflowed, input ready);
  modport sink   (input valid, input found, input overflowed, output ready);

endinterface : pds_out_if

@@ rtl/core/pds_ram.sv @@
// ----------------------------------------------------------------------------
// pds_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : pds_ram

@@ rtl/core/pair_difference_search.sv @@
// ----------------------------------------------------------------------------
// pair_difference_search
// Loads a set of signed values, sorts it and decides by a two-pointer scan
// whether two distinct entries differ by the configured target magnitude.
// ----------------------------------------------------------------------------
// Elements are taken one word per cycle and written straight into the element
// RAM. The word marked last closes the set; the block then drops ready while
// it sorts the set in place (insertion sort through the one RAM read port,
// one key at a time, shifting each larger entry up by one) and runs the
// two-pointer scan (one RAM read per pointer step). One result word follows,
// held in an output register, and the block takes new elements while it
// waits to be read. Words beyond MAX_ELEMENTS are dropped and reported
// through overflowed. The RAM read port sets the pace of both phases.
module pair_difference_search #(
  parameter int unsigned MAX_ELEMENTS = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [pds_pkg::VALUE_W-1:0] cfg_wdata,
  pds_in_if.sink                 in_ch,
  pds_out_if.source              out_ch
);
  import pds_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_SORT_I, S_KEY, S_CMP, S_PLACE,
    S_SCAN0, S_SCAN1, S_SCAN2, S_PAIR, S_HI, S_LO, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]      count_r, count_nxt;
  logic               dropped_r, dropped_nxt;
  value_t             target_r;
  logic [VALUE_W:0]   tmag_r, tmag_nxt;
  logic [CW-1:0]      i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt;
  value_t             key_r, key_nxt;
  value_t             lo_val_r, lo_val_nxt, hi_val_r, hi_val_nxt;
  logic               hit_r, hit_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               found_r, found_nxt;
  logic               ovf_r, ovf_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  value_t             ram_wdata;
  logic [VALUE_W-1:0] ram_rdata;
  value_t             rd_val;

  logic               in_fire;
  logic [VALUE_W:0]   tgt_sx;
  logic signed [VALUE_W:0]   diff;
  logic signed [VALUE_W+1:0] diff_x, tmag_x;
  logic               diff_eq, diff_lt, ptr_ok;

  // Element storage.
  pds_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_val = value_t'(ram_rdata);

  // Handshake outputs.
  assign in_ch.ready       = (state_r == S_LOAD);
  assign in_fire           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = found_r;
  assign out_ch.overflowed = ovf_r;

  // Target sign-extended to 33 bits.
  assign tgt_sx = {target_r[VALUE_W-1], target_r};

  // Shared compare unit: 33-bit difference of the two pointed entries.
  assign diff    = $signed({hi_val_r[VALUE_W-1], hi_val_r})
                 - $signed({lo_val_r[VALUE_W-1], lo_val_r});
  assign diff_x  = {diff[VALUE_W], diff};
  assign tmag_x  = $signed({1'b0, tmag_r});
  assign diff_eq = (diff_x == tmag_x);
  assign diff_lt = (diff_x < tmag_x);
  assign ptr_ok  = (lo_r < count_r) && (hi_r < count_r);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    tmag_nxt      = tmag_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    key_nxt       = key_r;
    lo_val_nxt    = lo_val_r;
    hi_val_nxt    = hi_val_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    ovf_nxt       = ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = in_ch.value;
    ram_raddr     = i_r[AW-1:0];

    // The result word leaves when it is taken.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          if (count_r < CW'(MAX_ELEMENTS)) begin
            ram_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_ch.last) begin
            i_nxt     = CW'(1);
            state_nxt = S_SORT_I;
          end
        end
      end

      // Fetch the next key, or move on to the scan when sorted.
      S_SORT_I: begin
        ram_raddr = i_r[AW-1:0];
        if (i_r >= count_r) begin
          state_nxt = S_SCAN0;
        end else begin
          state_nxt = S_KEY;
        end
      end

      S_KEY: begin
        key_nxt   = rd_val;
        j_nxt     = i_r;
        ram_raddr = AW'(i_r - 1'b1);
        state_nxt = S_CMP;
      end

      // Shift larger entries up by one until the key's slot is found.
      S_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[AW-1:0];
        if (rd_val > key_r) begin
          ram_wdata = rd_val;
          j_nxt     = j_r - 1'b1;
          ram_raddr = AW'(j_r - CW'(2));
          if (j_r == CW'(1)) begin
            state_nxt = S_PLACE;
          end
        end else begin
          ram_wdata = key_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SORT_I;
        end
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[AW-1:0];
        ram_wdata = key_r;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_SORT_I;
      end

      // Prime both pointers with the first two entries.
      S_SCAN0: begin
        tmag_nxt  = tgt_sx[VALUE_W] ? ((VALUE_W+1)'(0) - tgt_sx) : tgt_sx;
        lo_nxt    = '0;
        hi_nxt    = CW'(1);
        hit_nxt   = 1'b0;
        ram_raddr = '0;
        state_nxt = S_SCAN1;
      end

      S_SCAN1: begin
        lo_val_nxt = rd_val;
        ram_raddr  = AW'(1);
        state_nxt  = S_SCAN2;
      end

      S_SCAN2: begin
        hi_val_nxt = rd_val;
        state_nxt  = S_PAIR;
      end

      // One pointer step per comparison.
      S_PAIR: begin
        if (!ptr_ok) begin
          state_nxt = S_DONE;
        end else if ((lo_r != hi_r) && diff_eq) begin
          hit_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (diff_lt) begin
          hi_nxt    = hi_r + 1'b1;
          ram_raddr = AW'(hi_r + 1'b1);
          state_nxt = S_HI;
        end else begin
          lo_nxt    = lo_r + 1'b1;
          ram_raddr = AW'(lo_r + 1'b1);
          state_nxt = S_LO;
        end
      end

      S_HI: begin
        hi_val_nxt = rd_val;
        state_nxt  = S_PAIR;
      end

      S_LO: begin
        lo_val_nxt = rd_val;
        state_nxt  = S_PAIR;
      end

      // Hand the result to the output register and empty the set.
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          found_nxt     = hit_r;
          ovf_nxt       = dropped_r;
          count_nxt     = '0;
          dropped_nxt   = 1'b0;
          state_nxt     = S_LOAD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_we) begin
      target_r <= value_t'(cfg_wdata);
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tmag_r   <= tmag_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    key_r    <= key_nxt;
    lo_val_r <= lo_val_nxt;
    hi_val_r <= hi_val_nxt;
    hit_r    <= hit_nxt;
    found_r  <= found_nxt;
    ovf_r    <= ovf_nxt;
  end

  // The fill count never passes the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  // A dropped word only happens with a full store.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    dropped_r |-> (count_r == CW'(MAX_ELEMENTS)))
    else $error("drop flag set with room left");

  // The insertion pointer stays within the sorted prefix.
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ((j_r >= CW'(1)) && (j_r <= i_r)))
    else $error("shift pointer out of range");

  // Closing a set stops intake on the next cycle.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.last) |=> !in_ch.ready)
    else $error("input still ready after last word");

endmodule : pair_difference_search
